@@ src/cdq_pkg.sv @@
// Shared types, constants and ring index helper for the circular deque.
// Used by cdq_ctrl, cdq_dp and circular_deque; depends on nothing.
package cdq_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = 7;
	localparam int WORD_W  = 32;
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_POP_BACK   = 3'd1,
		REQ_PUSH_FRONT = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_SEARCH     = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture a new request
		logic exec;       // perform push/pop update and issue pop read
		logic pop_take;   // take popped word from the store read port
		logic scan_init;  // clear search offset
		logic scan_rd;    // read entry at current search offset
		logic scan_next;  // advance search offset
		logic found;      // search hit
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_search;
		logic is_pop;
		logic empty;
		logic match;
		logic last;
	} status_t;

	// Slot of the entry at offset off from head, wrapped by compare and subtract
	function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] off, input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] s;
		s = {{(CNT_W+1-IDX_W){1'b0}}, head} + {1'b0, off};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		if (s >= (CNT_W+1)'(DEPTH)) begin
			s = '0;
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

@@ src/circular_deque.sv @@
// Circular deque of 64 signed 32-bit words: push/pop at both ends and search.
// Result strobe (done) comes in S_DONE: after S_EXEC for pushes and unknown
// requests, via S_POP_WAIT for pops, and via S_SCAN_RD (store read) and
// S_SCAN_CMP (compare) per entry for a search. busy stays high until the strobe
// cycle ends; the next transaction is taken after that. Reset empties the deque
// and sets capacity to 64; store contents are undefined until written.
module circular_deque (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        req_type,
	input  logic signed [cdq_pkg::WORD_W-1:0] value,
	input  logic                              capacity_we,
	input  logic [cdq_pkg::CNT_W-1:0]         capacity_wdata,
	output logic                              done,
	output logic                              ok,
	output logic signed [cdq_pkg::WORD_W-1:0] data_out,
	output logic [cdq_pkg::CNT_W-1:0]         count,
	output logic                              is_full,
	output logic                              is_empty
);
	import cdq_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequence each transaction
	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// store, pointers and result registers
	cdq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.req_type       (req_type),
		.value          (value),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.ok             (ok),
		.data_out       (data_out),
		.count          (count),
		.is_full        (is_full),
		.is_empty       (is_empty)
	);

endmodule

@@ src/cdq_ctrl.sv @@
// Controller state machine for the circular deque.
// Sequences request capture, execution, pop read and search walk; uses cdq_pkg.
module cdq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cdq_pkg::status_t status,
	output cdq_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	import cdq_pkg::*;

	state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// decide next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (status.is_search) begin
					cmd.scan_init = 1'b1;
					state_d = status.empty ? S_DONE : S_SCAN_RD;
				end else if (status.is_pop) begin
					state_d = S_POP_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_POP_WAIT: begin
				cmd.pop_take = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (status.match) begin
					cmd.found = 1'b1;
					state_d = S_DONE;
				end else if (status.last) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_DONE: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/cdq_dp.sv @@
// Datapath for the circular deque: ring store, head, count, capacity and result.
// Driven by cdq_ctrl commands; uses cdq_pkg.
module cdq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cdq_pkg::cmd_t                     cmd,
	output cdq_pkg::status_t                  status,
	input  logic [2:0]                        req_type,
	input  logic signed [cdq_pkg::WORD_W-1:0] value,
	input  logic                              capacity_we,
	input  logic [cdq_pkg::CNT_W-1:0]         capacity_wdata,
	output logic                              ok,
	output logic signed [cdq_pkg::WORD_W-1:0] data_out,
	output logic [cdq_pkg::CNT_W-1:0]         count,
	output logic                              is_full,
	output logic                              is_empty
);
	import cdq_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;
	logic [2:0]        req_q;
	logic [WORD_W-1:0] value_q;
	logic [CNT_W-1:0]  capacity_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  off_q;
	logic              ok_q;
	logic [WORD_W-1:0] data_q;

	logic [CNT_W-1:0]  cap;
	logic              full, empty;
	logic [CNT_W-1:0]  count_m1;
	logic [IDX_W-1:0]  head_dec, head_inc;
	logic [CNT_W-1:0]  head_p1;
	logic              wr_en, rd_en;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	logic              upd_ok;
	logic [IDX_W-1:0]  head_d;
	logic [CNT_W-1:0]  count_d;

	// effective capacity and occupancy flags
	assign cap      = (capacity_q > DEPTH_CNT) ? DEPTH_CNT : capacity_q;
	assign full     = (count_q >= cap);
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CNT_W'(1);
	assign head_p1  = {{(CNT_W-IDX_W){1'b0}}, head_q} + CNT_W'(1);
	assign head_dec = (head_q == '0) ? IDX_W'(cap - CNT_W'(1)) : head_q - IDX_W'(1);
	assign head_inc = (head_p1 >= cap) ? IDX_W'(head_p1 - cap) : IDX_W'(head_p1);

	// decode the request being executed
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ring_slot(head_q, count_q, cap);
		rd_en   = cmd.scan_rd;
		rd_addr = ring_slot(head_q, off_q, cap);
		upd_ok  = 1'b0;
		head_d  = head_q;
		count_d = count_q;
		if (cmd.exec) begin
			unique case (req_q)
				REQ_PUSH_BACK: begin
					if (!full) begin
						wr_en   = 1'b1;
						upd_ok  = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				REQ_POP_BACK: begin
					if (!empty) begin
						rd_en   = 1'b1;
						rd_addr = ring_slot(head_q, count_m1, cap);
						upd_ok  = 1'b1;
						count_d = count_m1;
					end
				end
				REQ_PUSH_FRONT: begin
					if (!full) begin
						wr_en   = 1'b1;
						wr_addr = head_dec;
						head_d  = head_dec;
						upd_ok  = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				REQ_POP_FRONT: begin
					if (!empty) begin
						rd_en   = 1'b1;
						rd_addr = head_q;
						head_d  = head_inc;
						upd_ok  = 1'b1;
						count_d = count_m1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ring store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// capture the request transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			value_q <= value;
		end
	end

	// hold capacity, head and count; a capacity write empties the deque
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			head_q     <= '0;
			count_q    <= '0;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
			head_q     <= '0;
			count_q    <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// search offset
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			off_q <= '0;
		end else if (cmd.scan_next) begin
			off_q <= off_q + CNT_W'(1);
		end
	end

	// result flag and popped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= 1'b0;
			data_q <= '0;
		end else if (cmd.load) begin
			ok_q   <= 1'b0;
			data_q <= '0;
		end else begin
			if (upd_ok || cmd.found) begin
				ok_q <= 1'b1;
			end
			if (cmd.pop_take && ok_q) begin
				data_q <= rdata_q;
			end
		end
	end

	assign status.is_search = (req_q == REQ_SEARCH);
	assign status.is_pop    = (req_q == REQ_POP_BACK) || (req_q == REQ_POP_FRONT);
	assign status.empty     = empty;
	assign status.match     = (rdata_q == value_q);
	assign status.last      = ((off_q + CNT_W'(1)) >= count_q);

	assign ok       = ok_q;
	assign data_out = data_q;
	assign count    = count_q;
	assign is_full  = (count_q == cap);
	assign is_empty = empty;

endmodule
